// ----- hw/rtl/sacm_pkg.sv -----
// ----------------------------------------------------------------------------
// sacm_pkg
// Types and constants shared by the serial ADC conversion master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sacm_pkg;

    // Bits shifted in per conversion
    localparam int unsigned SAMPLE_BITS = 8;
    // Start bit, single-ended bit, channel bit
    localparam int unsigned WRITE_BITS  = 3;
    localparam int unsigned BIT_CNT_W   = 3;
    localparam int unsigned HALF_W      = 16;
    localparam logic [HALF_W-1:0] HALF_RESET = 16'd100;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SETUP = 3'd1,
        PH_WRITE = 3'd2,
        PH_READ  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [BIT_CNT_W-1:0]   bit_count;
        logic [HALF_W-1:0]      delay_count;
        logic [SAMPLE_BITS-1:0] shift_value;
        logic                   channel_latch;
        logic                   clock_level;
    } seq_state_t;

    // First member sits in the highest bits: select_n lands at bit 0
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   done_res;
        logic                   busy_res;
        logic                   data_pin_drive;
        logic                   data_pin_out;
        logic                   serial_clock;
        logic                   select_n;
    } seq_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sacm_step.sv -----
// ----------------------------------------------------------------------------
// sacm_step
// One tick of the conversion sequencer: next state and pin levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sacm_step (
    input  sacm_pkg::seq_state_t     cur,
    input  logic [sacm_pkg::HALF_W-1:0] half_ticks,
    input  logic                     start_req,
    input  logic                     channel,
    input  logic                     data_pin_in,
    output sacm_pkg::seq_state_t     nxt,
    output sacm_pkg::seq_result_t    res
);
    import sacm_pkg::*;

    logic [HALF_W-1:0] h;
    logic [HALF_W:0]   delay_inc;
    logic              elapsed;
    logic              busy;

    // A zero half period acts as one tick
    assign h         = (half_ticks == '0) ? {{(HALF_W-1){1'b0}}, 1'b1} : half_ticks;
    assign delay_inc = {1'b0, cur.delay_count} + {{HALF_W{1'b0}}, 1'b1};
    assign elapsed   = !(delay_inc < {1'b0, h});

    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            PH_SETUP:
            begin
                nxt.delay_count = elapsed ? '0 : delay_inc[HALF_W-1:0];
                if (elapsed)
                begin
                    nxt.phase       = PH_WRITE;
                    nxt.bit_count   = '0;
                    nxt.clock_level = 1'b1;
                end
            end
            PH_WRITE:
            begin
                nxt.delay_count = elapsed ? '0 : delay_inc[HALF_W-1:0];
                if (elapsed)
                begin
                    if (cur.clock_level)
                    begin
                        nxt.clock_level = 1'b0;
                    end
                    else if (cur.bit_count == BIT_CNT_W'(WRITE_BITS - 1))
                    begin
                        nxt.phase       = PH_READ;
                        nxt.bit_count   = '0;
                        nxt.clock_level = 1'b1;
                    end
                    else
                    begin
                        nxt.bit_count   = cur.bit_count + 1'b1;
                        nxt.clock_level = 1'b1;
                    end
                end
            end
            PH_READ:
            begin
                nxt.delay_count = elapsed ? '0 : delay_inc[HALF_W-1:0];
                if (elapsed)
                begin
                    if (cur.clock_level)
                    begin
                        // sample at the end of the clock-high half
                        nxt.shift_value = {cur.shift_value[SAMPLE_BITS-2:0], data_pin_in};
                        nxt.clock_level = 1'b0;
                    end
                    else if (cur.bit_count == BIT_CNT_W'(SAMPLE_BITS - 1))
                    begin
                        nxt.phase     = PH_DONE;
                        nxt.bit_count = '0;
                    end
                    else
                    begin
                        nxt.bit_count   = cur.bit_count + 1'b1;
                        nxt.clock_level = 1'b1;
                    end
                end
            end
            default:
            begin
                nxt.clock_level = 1'b0;
                if (start_req)
                begin
                    nxt.channel_latch = channel;
                    nxt.phase         = PH_SETUP;
                    nxt.delay_count   = '0;
                    nxt.bit_count     = '0;
                end
                else
                begin
                    nxt.phase = PH_IDLE;
                end
            end
        endcase
    end

    assign busy = (nxt.phase == PH_SETUP) || (nxt.phase == PH_WRITE) || (nxt.phase == PH_READ);

    always_comb
    begin
        res.select_n       = !busy;
        res.serial_clock   = busy & nxt.clock_level;
        res.busy_res       = busy;
        res.done_res       = (nxt.phase == PH_DONE);
        res.data_pin_drive = (nxt.phase != PH_READ);
        res.sample         = busy ? '0 : nxt.shift_value;
        case (nxt.phase)
            PH_WRITE: res.data_pin_out = (nxt.bit_count < BIT_CNT_W'(WRITE_BITS - 1)) ?
                                         1'b1 : nxt.channel_latch;
            PH_READ:  res.data_pin_out = 1'b0;
            default:  res.data_pin_out = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/serial_adc_conversion_master_unit.sv -----
// ----------------------------------------------------------------------------
// serial_adc_conversion_master_unit
// Pin-level master for a three-wire serial ADC, one tick per input word.
// ----------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_*       in   8      tdata: start_req, channel, data_pin_in (bit 0 up)
// m_*       out  16     tdata: select_n, serial_clock, data_pin_out,
//                       data_pin_drive, busy_res, done_res, sample[7:0]
// cfg_*     in   16     half_period_ticks, reset value 100
//
// One word in, one word out; a word is accepted every cycle while the output register is empty or being drained.
// The sequencer state advances on each accepted word and its result is held
// in a single output register, valid in the cycle after the word is accepted.
// s_tready stays high while the output register is empty or being drained.
// rst_n clears the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_adc_conversion_master_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // start_req, channel, data_pin_in, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // select_n, serial_clock, data_pin_out,
                                   // data_pin_drive, busy_res, done_res,
                                   // sample[7:0], zero pad
);
    import sacm_pkg::*;

    logic [HALF_W-1:0] half_reg;
    seq_state_t        state_reg;
    seq_state_t        state_next;
    seq_result_t       res_next;
    seq_result_t       res_reg;
    logic              m_valid_reg;
    logic              s_accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, res_reg};

    sacm_step u_step (
        .cur         (state_reg),
        .half_ticks  (half_reg),
        .start_req   (s_tdata[0]),
        .channel     (s_tdata[1]),
        .data_pin_in (s_tdata[2]),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_RESET;
        end
        else if (cfg_we)
        begin
            half_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '{phase: PH_IDLE, default: '0};
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                state_reg <= state_next;
            end
            // drop the word once taken, refill on accept
            if (s_accept)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            res_reg <= res_next;
        end
    end

    // done and busy never share a word
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(res_reg.done_res && res_reg.busy_res))
        else $error("done and busy both set");

    // serial clock idles low whenever chip select is high
    a_clk_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && res_reg.select_n) |-> !res_reg.serial_clock)
        else $error("serial clock high while deselected");

    // after the done tick the sequencer returns to idle or restarts
    a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && state_reg.phase == PH_DONE) |=>
        (state_reg.phase == PH_IDLE || state_reg.phase == PH_SETUP))
        else $error("bad exit from done");

    // the busy flag of the output word matches the state it was computed from
    a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (res_reg.busy_res == (state_reg.phase == PH_SETUP ||
                      state_reg.phase == PH_WRITE || state_reg.phase == PH_READ)))
        else $error("busy flag does not follow phase");

endmodule

`default_nettype wire

// ----- tb/sv/tb_serial_adc_conversion_master_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_adc_conversion_master_unit
// Drives tick words into the serial ADC master and predicts the pin levels,
// busy/done flags and sample of every result word, checking each one in
// order. Covers the reset half period, a zero half period, back-to-back
// conversions, starts while busy, the widest half period, random traffic
// under several idle patterns and a long output stall.
// ----------------------------------------------------------------------------

module tb_serial_adc_conversion_master_unit;

    import sacm_pkg::*;

    // Run limit, set well above the slowest run to leave plenty of room
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned RANDOM_WORDS = 240;

    typedef enum logic [1:0] {
        DIN_RANDOM,
        DIN_HIGH,
        DIN_LOW
    } din_src_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [15:0] cfg_data = 16'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // start_req, channel, data_pin_in, zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // select_n, serial_clock, data_pin_out,
                                    // data_pin_drive, busy_res, done_res,
                                    // sample[7:0], zero pad

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned stall_req    = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt    = 0;

    seq_result_t pin_levels_q[$];

    // Sequencer copy used for prediction
    phase_t      mdl_phase = PH_IDLE;
    logic [3:0]  mdl_bits  = 4'd0;
    logic [15:0] mdl_delay = 16'd0;
    logic [7:0]  mdl_shift = 8'd0;
    logic        mdl_chan  = 1'b0;
    logic        mdl_clk   = 1'b0;
    logic [15:0] mdl_half  = HALF_RESET;

    serial_adc_conversion_master_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a forced hold-off when requested
    always @(posedge clk)
    begin
        if (stall_req > 0)
        begin
            m_tready  <= 1'b0;
            stall_req = stall_req - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // True when the current half period ends on this tick
    function automatic logic half_done(int unsigned h);
        if (int'(mdl_delay) + 1 < h)
        begin
            mdl_delay = mdl_delay + 16'd1;
            return 1'b0;
        end
        mdl_delay = 16'd0;
        return 1'b1;
    endfunction

    function automatic seq_result_t adc_tick(logic st, logic ch, logic di);
        int unsigned h;
        logic        busy;
        seq_result_t r;
        h = (mdl_half == 16'd0) ? 1 : int'(mdl_half);
        case (mdl_phase)
            PH_SETUP:
            begin
                if (half_done(h))
                begin
                    mdl_phase = PH_WRITE;
                    mdl_bits  = 4'd0;
                    mdl_clk   = 1'b1;
                end
            end
            PH_WRITE:
            begin
                if (half_done(h))
                begin
                    if (mdl_clk)
                    begin
                        mdl_clk = 1'b0;
                    end
                    else if (mdl_bits >= WRITE_BITS - 1)
                    begin
                        mdl_phase = PH_READ;
                        mdl_bits  = 4'd0;
                        mdl_clk   = 1'b1;
                    end
                    else
                    begin
                        mdl_bits = mdl_bits + 4'd1;
                        mdl_clk  = 1'b1;
                    end
                end
            end
            PH_READ:
            begin
                if (half_done(h))
                begin
                    if (mdl_clk)
                    begin
                        mdl_shift = {mdl_shift[6:0], di};
                        mdl_clk   = 1'b0;
                    end
                    else if (int'(mdl_bits) + 1 >= SAMPLE_BITS)
                    begin
                        mdl_phase = PH_DONE;
                        mdl_bits  = 4'd0;
                    end
                    else
                    begin
                        mdl_bits = mdl_bits + 4'd1;
                        mdl_clk  = 1'b1;
                    end
                end
            end
            default:
            begin
                if (st)
                begin
                    mdl_chan  = ch;
                    mdl_phase = PH_SETUP;
                    mdl_delay = 16'd0;
                    mdl_bits  = 4'd0;
                end
                else
                begin
                    mdl_phase = PH_IDLE;
                end
                mdl_clk = 1'b0;
            end
        endcase

        busy = (mdl_phase == PH_SETUP) || (mdl_phase == PH_WRITE) ||
               (mdl_phase == PH_READ);
        r.select_n       = !busy;
        r.serial_clock   = busy & mdl_clk;
        if (mdl_phase == PH_WRITE)
            r.data_pin_out = (mdl_bits < WRITE_BITS - 1) ? 1'b1 : mdl_chan;
        else
            r.data_pin_out = (mdl_phase != PH_READ);
        r.data_pin_drive = (mdl_phase != PH_READ);
        r.busy_res       = busy;
        r.done_res       = (mdl_phase == PH_DONE);
        r.sample         = busy ? 8'd0 : mdl_shift;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        seq_result_t got;
        seq_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = seq_result_t'(m_tdata[13:0]);
            if (pin_levels_q.size() == 0)
            begin
                $display("%0t ns: unexpected word, expected none, got %h", $time, m_tdata);
                mismatch_cnt++;
            end
            else
            begin
                want = pin_levels_q.pop_front();
                check_field("select_n", want.select_n, got.select_n);
                check_field("serial_clock", want.serial_clock, got.serial_clock);
                check_field("data_pin_out", want.data_pin_out, got.data_pin_out);
                check_field("data_pin_drive", want.data_pin_drive, got.data_pin_drive);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("done_res", want.done_res, got.done_res);
                check_field("sample", want.sample, got.sample);
            end
        end
    end

    task automatic send_word(input logic st, input logic ch, input logic di);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, di, ch, st};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pin_levels_q.push_back(adc_tick(st, ch, di));
    endtask

    // Hold the input until every result has come back
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pin_levels_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_half_period(input logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        mdl_half = value;
    endtask

    // Start on this word and run until the done tick has been sent
    task automatic run_conversion(input logic ch, input din_src_t src, input logic poke);
        logic di;
        send_word(1'b1, ch, 1'($urandom_range(1)));
        while (mdl_phase != PH_DONE)
        begin
            case (src)
                DIN_HIGH: di = 1'b1;
                DIN_LOW:  di = 1'b0;
                default:  di = 1'($urandom_range(1));
            endcase
            send_word(poke & 1'($urandom_range(1)), 1'($urandom_range(1)), di);
        end
    endtask

    task automatic test_reset_half_period();
        src_idle_pct = 32;
        snk_idle_pct = 76;
        send_word(1'b0, 1'b1, 1'b1);
        send_word(1'b1, 1'b1, 1'b0);
        // Run through the setup delay and into the first clock-high half
        repeat (150)
            send_word(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
        wait_quiet();
        // Shorten the half period and run the conversion out
        write_half_period(16'd1);
        while (mdl_phase != PH_DONE)
            send_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        send_word(1'b0, 1'b0, 1'b0);
        wait_quiet();
    endtask

    task automatic test_directed_cases();
        // Zero half period behaves as one tick
        write_half_period(16'd0);
        send_word(1'b0, 1'b0, 1'b1);
        run_conversion(1'b0, DIN_HIGH, 1'b1);
        // Start straight after the done tick
        run_conversion(1'b1, DIN_LOW, 1'b0);
        send_word(1'b0, 1'b1, 1'b0);
        wait_quiet();
        write_half_period(16'd1);
        run_conversion(1'b1, DIN_RANDOM, 1'b1);
        wait_quiet();
    endtask

    task automatic test_random_traffic();
        int unsigned mode;
        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    src_idle_pct = 32;
                    snk_idle_pct = 76;
                    write_half_period(16'd1);
                end
                1:
                begin
                    src_idle_pct = 76;
                    snk_idle_pct = 32;
                    write_half_period(16'd4);
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    write_half_period(16'($urandom_range(2, 8)));
                end
            endcase
            repeat (RANDOM_WORDS)
                send_word($urandom_range(5) == 0, 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            wait_quiet();
        end
    endtask

    task automatic test_max_half_period();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_half_period(16'hFFFF);
        send_word(1'b1, 1'b0, 1'b1);
        repeat (250)
            send_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        wait_quiet();
        // Shorten mid setup, then run the conversion out
        write_half_period(16'd2);
        while (mdl_phase != PH_IDLE && mdl_phase != PH_DONE)
            send_word(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
        wait_quiet();
    endtask

    task automatic test_output_stall();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_half_period(16'd1);
        stall_req = 300;
        repeat (80)
            send_word($urandom_range(3) == 0, 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        wait_quiet();
        repeat (40)
            send_word($urandom_range(3) == 0, 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        wait_quiet();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_half_period();
        test_directed_cases();
        test_random_traffic();
        test_max_half_period();
        test_output_stall();

        repeat (4) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sacm_pkg.sv
hw/rtl/sacm_step.sv
hw/rtl/serial_adc_conversion_master_unit.sv
tb/sv/tb_serial_adc_conversion_master_unit.sv
